// ===== hdl/pvpc_pkg.sv =====
// shared constants, types and control structs of the pitch comb unit
// no dependencies
package pvpc_pkg;

    localparam int FFT_SIZE_DEF   = 1024;
    localparam int PEAK_COUNT_DEF = 8;

    localparam int BIN_W   = 10;
    localparam int LEVEL_W = 16;
    localparam int PHASE_W = 16;
    localparam int FREQ_W  = 24;
    localparam int PITCH_W = 20;
    localparam int STEP_W  = 16;
    localparam int HOP_W   = 7;
    localparam int MAXP_W  = 16;
    localparam int CFG_W   = 24;
    localparam int CFG_IDX_W = 2;
    localparam int S_DATA_W = 48;
    localparam int M_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] CFG_FREQ_PER_BIN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PHASE_STEP   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HOP_RATIO    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_PITCH    = 2'd3;

    localparam logic [FREQ_W-1:0]  FREQ_PER_BIN_RST = 24'd11025;
    localparam logic [STEP_W-1:0]  PHASE_STEP_RST   = 16'd32768;
    localparam logic [HOP_W-1:0]   HOP_RATIO_RST    = 7'd2;
    localparam logic [MAXP_W-1:0]  MAX_PITCH_RST    = 16'd5000;

    localparam logic [LEVEL_W-1:0] LEVEL_EMPTY = 16'h8000;
    localparam logic [FREQ_W-1:0]  FREQ_MAX    = 24'hFFFFFF;
    localparam int TOL_SCALE    = 50;
    localparam int TOP_HARMONIC = 5;

    typedef struct packed {
        logic clr_wr;
        logic load;
        logic dev;
        logic mul;
        logic push;
        logic pick;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic in_range;
        logic pick_done;
        logic clr_last;
        logic out_free;
    } t_sts;

endpackage

// ===== hdl/phase_vocoder_pitch_comb_unit.sv =====
// top level of the phase vocoder pitch comb unit
// depends on pvpc_pkg, pvpc_ctrl, pvpc_dp
//
//  channel  | direction | contents
//  s_axis   | in        | one spectrum bin, tlast ends the frame
//  m_axis   | out       | detected pitch, one per frame
//  cfg      | in        | register writes, index and data
//
// after reset a clearing pass zeroes all FFT_SIZE/2+1 entries of the phase memory
// an in-range bin goes through the steps read, phase deviation, multiply and peak push
// the last bin adds a scan of up to PEAK_COUNT-1 peak list entries and an output step
// a pending pitch stalls only the next frame end, until m_axis_tready
module phase_vocoder_pitch_comb_unit #(
    parameter int FFT_SIZE   = pvpc_pkg::FFT_SIZE_DEF,
    parameter int PEAK_COUNT = pvpc_pkg::PEAK_COUNT_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [pvpc_pkg::S_DATA_W-1:0]   s_axis_tdata,  // bin_index, level_db, phase_turns
    input  logic                            s_axis_tlast,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [pvpc_pkg::M_DATA_W-1:0]   m_axis_tdata,  // pitch_hz_q4
    input  logic                            i_cfg_we,
    input  logic [pvpc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [pvpc_pkg::CFG_W-1:0]      i_cfg_wdata
);
    import pvpc_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;
    logic [PITCH_W-1:0] w_pitch;

    pvpc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .i_last  (s_axis_tlast),
        .o_ready (s_axis_tready),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    pvpc_dp #(
        .FFT_SIZE   (FFT_SIZE),
        .PEAK_COUNT (PEAK_COUNT)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_bin       (s_axis_tdata[BIN_W-1:0]),
        .i_level     (s_axis_tdata[BIN_W+LEVEL_W-1:BIN_W]),
        .i_phase     (s_axis_tdata[BIN_W+LEVEL_W+PHASE_W-1:BIN_W+LEVEL_W]),
        .i_out_ready (m_axis_tready),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .o_out_valid (m_axis_tvalid),
        .o_pitch     (w_pitch)
    );

    assign m_axis_tdata = {{(M_DATA_W-PITCH_W){1'b0}}, w_pitch};

    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.clr_wr |-> !s_axis_tready)
        else $error("request accepted during memory clear");

    a_out_load_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_load |=> m_axis_tvalid)
        else $error("pitch load did not raise valid");

    a_out_only_at_frame_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_load |-> !s_axis_tready && !w_cmd.pick)
        else $error("pitch load outside frame end");

endmodule

// ===== hdl/pvpc_ctrl.sv =====
// sequencer of the pitch comb unit: clearing pass, per-bin steps, harmonic scan, output step
// depends on pvpc_pkg
module pvpc_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  logic            i_last,
    output logic            o_ready,
    input  pvpc_pkg::t_sts  i_sts,
    output pvpc_pkg::t_cmd  o_cmd
);
    import pvpc_pkg::*;

    localparam logic [2:0] S_CLR  = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_DEV  = 3'd2;
    localparam logic [2:0] S_MUL  = 3'd3;
    localparam logic [2:0] S_PUSH = 3'd4;
    localparam logic [2:0] S_PICK = 3'd5;
    localparam logic [2:0] S_OUT  = 3'd6;

    logic [2:0] r_state, n_state;
    logic       r_last, n_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_last  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_last  <= n_last;
        end
    end

    always_comb begin
        n_state = r_state;
        n_last  = r_last;
        o_cmd   = '0;
        o_ready = 1'b0;
        case (r_state)
            S_CLR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_sts.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_last     = i_last;
                    if (i_sts.in_range) n_state = S_DEV;
                    else if (i_last)    n_state = S_PICK;
                end
            end
            S_DEV: begin
                o_cmd.dev = 1'b1;
                n_state   = S_MUL;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_PUSH;
            end
            S_PUSH: begin
                o_cmd.push = 1'b1;
                n_state    = r_last ? S_PICK : S_IDLE;
            end
            S_PICK: begin
                o_cmd.pick = 1'b1;
                if (i_sts.pick_done) n_state = S_OUT;
            end
            S_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_CLR;
        endcase
    end

endmodule

// ===== hdl/pvpc_dp.sv =====
// datapath of the pitch comb unit: config registers, phase memory, frequency math, peak list, output register
// depends on pvpc_pkg
module pvpc_dp #(
    parameter int FFT_SIZE   = pvpc_pkg::FFT_SIZE_DEF,
    parameter int PEAK_COUNT = pvpc_pkg::PEAK_COUNT_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [pvpc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [pvpc_pkg::CFG_W-1:0]      i_cfg_wdata,
    input  logic [pvpc_pkg::BIN_W-1:0]      i_bin,
    input  logic [pvpc_pkg::LEVEL_W-1:0]    i_level,
    input  logic [pvpc_pkg::PHASE_W-1:0]    i_phase,
    input  logic                            i_out_ready,
    input  pvpc_pkg::t_cmd                  i_cmd,
    output pvpc_pkg::t_sts                  o_sts,
    output logic                            o_out_valid,
    output logic [pvpc_pkg::PITCH_W-1:0]    o_pitch
);
    import pvpc_pkg::*;

    localparam int HALF_BINS = FFT_SIZE / 2 + 1;
    localparam int AW = $clog2(HALF_BINS);
    localparam int LW = $clog2(PEAK_COUNT);
    localparam int CW = $clog2(PEAK_COUNT + 1);

    logic [FREQ_W-1:0] r_fpb;
    logic [STEP_W-1:0] r_step;
    logic [HOP_W-1:0]  r_hop;
    logic [MAXP_W-1:0] r_max;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fpb  <= FREQ_PER_BIN_RST;
            r_step <= PHASE_STEP_RST;
            r_hop  <= HOP_RATIO_RST;
            r_max  <= MAX_PITCH_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_FREQ_PER_BIN: r_fpb  <= i_cfg_wdata;
                CFG_PHASE_STEP:   r_step <= i_cfg_wdata[STEP_W-1:0];
                CFG_HOP_RATIO:    r_hop  <= i_cfg_wdata[HOP_W-1:0];
                CFG_MAX_PITCH:    r_max  <= i_cfg_wdata[MAXP_W-1:0];
                default: ;
            endcase
        end
    end

    // phase memory and clearing pass
    logic [PHASE_W-1:0] r_mem [HALF_BINS];
    logic [PHASE_W-1:0] r_rd;
    logic [AW-1:0]      r_clr;
    logic [AW-1:0]      r_addr;
    logic [31:0]        w_bin_ext;
    logic [AW-1:0]      w_ra, w_wa;
    logic [PHASE_W-1:0] w_wd;
    logic               w_we;

    assign w_bin_ext = 32'(i_bin);
    assign w_ra = w_bin_ext[AW-1:0];
    assign w_wa = i_cmd.clr_wr ? r_clr : r_addr;
    assign w_we = i_cmd.clr_wr | i_cmd.dev;

    always_ff @(posedge i_clk) begin
        if (w_we) r_mem[w_wa] <= w_wd;
        r_rd <= r_mem[w_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_clr <= '0;
        else if (i_cmd.clr_wr) r_clr <= r_clr + 1'b1;
    end

    // per-bin registers
    logic [BIN_W-1:0]         r_bin;
    logic signed [LEVEL_W-1:0] r_level;
    logic [PHASE_W-1:0]       r_phase;
    logic [STEP_W-1:0]        r_bstep;
    logic [BIN_W+STEP_W-1:0]  w_bstep;
    logic [PHASE_W-1:0]       w_raw;
    logic signed [PHASE_W-1:0] w_dev;
    logic signed [HOP_W+PHASE_W:0] w_hd;
    logic signed [27:0]       w_bq, r_bq;
    logic signed [52:0]       r_prod;

    assign w_wd    = i_cmd.clr_wr ? '0 : r_phase;
    assign w_bstep = i_bin * r_step;
    assign w_raw = r_phase - r_rd - r_bstep;
    assign w_dev = $signed(w_raw);
    assign w_hd  = $signed({1'b0, r_hop}) * w_dev;
    assign w_bq  = $signed({2'b00, r_bin, 16'h0000}) + 28'(w_hd);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_bin   <= i_bin;
            r_level <= $signed(i_level);
            r_phase <= i_phase;
            r_addr  <= w_ra;
            r_bstep <= w_bstep[STEP_W-1:0];
        end
        if (i_cmd.dev) r_bq <= w_bq;
        if (i_cmd.mul) r_prod <= r_bq * $signed({1'b0, r_fpb});
    end

    logic [32:0]       w_sh;
    logic              w_pos;
    logic [FREQ_W-1:0] w_f;

    assign w_sh  = r_prod[52:20];
    assign w_pos = !r_prod[52] && (r_prod != '0);
    assign w_f   = !w_pos ? '0 : (w_sh > 33'(FREQ_MAX)) ? FREQ_MAX : w_sh[FREQ_W-1:0];

    // peak list and harmonic scan
    logic [FREQ_W-1:0]  r_pf [PEAK_COUNT];
    logic [LEVEL_W-1:0] r_pl [PEAK_COUNT];
    logic [CW-1:0]      r_l;
    logic [2:0]         r_best;
    logic [FREQ_W-1:0]  r_sel;
    logic [LW-1:0]      w_idx;
    logic [FREQ_W-1:0]  w_fl;
    logic               w_done, w_lvl_ok;
    logic [31:0]        w_t, w_lo, w_hi;
    logic [2:0]         w_hm;
    logic               w_push;

    assign w_idx  = r_l[LW-1:0];
    assign w_fl   = r_pf[w_idx];
    assign w_done = (r_l == CW'(PEAK_COUNT)) || (w_fl == '0);
    assign w_lvl_ok = $signed({r_pl[0], 1'b0}) < $signed({r_pl[w_idx][LEVEL_W-1], r_pl[w_idx]});
    assign w_t    = 32'(r_pf[0]) * 32'(TOL_SCALE);
    assign w_push = (w_f != '0) && ((r_pf[0] == '0) || (r_level > $signed(r_pl[0])));

    always_comb begin
        w_hm = '0;
        w_lo = '0;
        w_hi = '0;
        for (int h = 2; h <= TOP_HARMONIC; h++) begin
            w_lo = 32'(TOL_SCALE * h - 1) * 32'(w_fl);
            w_hi = 32'(TOL_SCALE * h + 1) * 32'(w_fl);
            if (w_t > w_lo && w_t < w_hi) w_hm = 3'(h);
        end
    end

    logic [FREQ_W-1:0] w_self;
    logic              r_ovalid;
    logic [PITCH_W-1:0] r_pitch;

    assign w_self = (r_best == '0) ? r_pf[0] : r_sel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < PEAK_COUNT; i++) begin
                r_pf[i] <= '0;
                r_pl[i] <= LEVEL_EMPTY;
            end
            r_ovalid <= 1'b0;
        end else begin
            if (i_cmd.push && w_push) begin
                for (int i = PEAK_COUNT - 1; i > 0; i--) begin
                    r_pf[i] <= r_pf[i-1];
                    r_pl[i] <= r_pl[i-1];
                end
                r_pf[0] <= w_f;
                r_pl[0] <= r_level;
            end
            if (i_cmd.out_load) begin
                for (int i = 0; i < PEAK_COUNT; i++) begin
                    r_pf[i] <= '0;
                    r_pl[i] <= LEVEL_EMPTY;
                end
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_l    <= CW'(1);
            r_best <= '0;
        end else if (i_cmd.pick && !w_done) begin
            r_l <= r_l + 1'b1;
            if (w_lvl_ok && w_hm > r_best) begin
                r_best <= w_hm;
                r_sel  <= w_fl;
            end
        end
        if (i_cmd.out_load)
            r_pitch <= (w_self > {4'h0, r_max, 4'h0}) ? '0 : w_self[PITCH_W-1:0];
    end

    assign o_sts.in_range  = w_bin_ext < 32'(HALF_BINS);
    assign o_sts.pick_done = w_done;
    assign o_sts.clr_last  = (32'(r_clr) == 32'(HALF_BINS - 1));
    assign o_sts.out_free  = !r_ovalid || i_out_ready;
    assign o_out_valid     = r_ovalid;
    assign o_pitch         = r_pitch;

endmodule

// ===== sim/phase_vocoder_pitch_comb_unit_tb.sv =====
// self-checking bench of the phase vocoder pitch comb unit: streams bins, predicts the pitch
// of every frame in-bench and compares each m_axis request; depends on pvpc_pkg and the unit
module phase_vocoder_pitch_comb_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import pvpc_pkg::*;

    localparam int HALF = FFT_SIZE_DEF / 2 + 1;
    localparam int NPK  = PEAK_COUNT_DEF;

    typedef struct packed {
        logic [BIN_W-1:0]   bin;
        logic [LEVEL_W-1:0] level;
        logic [PHASE_W-1:0] phase;
        logic               last;
    } t_bin;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [S_DATA_W-1:0] s_axis_tdata = '0;
    logic s_axis_tlast = 1'b0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [M_DATA_W-1:0] m_axis_tdata;
    logic i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [CFG_W-1:0] i_cfg_wdata = '0;

    phase_vocoder_pitch_comb_unit u_top (.*);

    always #1 i_clk = ~i_clk;

    logic [FREQ_W-1:0] cf_fpb = FREQ_PER_BIN_RST;
    logic [STEP_W-1:0] cf_step = PHASE_STEP_RST;
    logic [HOP_W-1:0]  cf_hop = HOP_RATIO_RST;
    logic [MAXP_W-1:0] cf_maxp = MAX_PITCH_RST;
    logic [PHASE_W-1:0] prev_ph [HALF];
    logic [FREQ_W-1:0] pk_f [NPK];
    logic signed [LEVEL_W-1:0] pk_l [NPK];

    t_bin bin_q[$];
    logic [PITCH_W-1:0] pitch_q[$];
    int errors = 0, frames = 0, sent = 0;
    bit hold = 0;

    task automatic report(input string msg);
        $display("mismatch: %s", msg);
        errors++;
    endtask

    function automatic logic [FREQ_W-1:0] true_freq(input int b, input logic [15:0] ph);
        logic [15:0] raw;
        longint dev, q16, prod;
        raw = ph - prev_ph[b] - 16'(b * cf_step);
        dev = longint'($signed(raw));
        q16 = longint'(b) * 65536 + longint'(cf_hop) * dev;
        prod = q16 * longint'(cf_fpb);
        if (prod <= 0) return '0;
        prod = prod >>> 20;
        return (prod > 64'hFFFFFF) ? FREQ_MAX : prod[23:0];
    endfunction

    function automatic logic [PITCH_W-1:0] pick_pitch();
        int sel, best;
        longint f0, fl;
        sel = 0; best = 0;
        f0 = longint'(pk_f[0]);
        for (int l = 1; l < NPK && pk_f[l] != 0; l++) begin
            fl = longint'(pk_f[l]);
            for (int h = TOP_HARMONIC; h > 1; h--)
                if (TOL_SCALE * f0 > (TOL_SCALE * h - 1) * fl &&
                    TOL_SCALE * f0 < (TOL_SCALE * h + 1) * fl && h > best &&
                    2 * int'(pk_l[0]) < int'(pk_l[l])) begin
                    best = h; sel = l;
                end
        end
        if (longint'(pk_f[sel]) > longint'(cf_maxp) * 16) return '0;
        return pk_f[sel][PITCH_W-1:0];
    endfunction

    task automatic clear_peaks();
        for (int i = 0; i < NPK; i++) begin
            pk_f[i] = '0; pk_l[i] = LEVEL_EMPTY;
        end
    endtask

    task automatic predict_bin(input t_bin x);
        logic [FREQ_W-1:0] f;
        if (x.bin < HALF) begin
            f = true_freq(x.bin, x.phase);
            prev_ph[x.bin] = x.phase;
            if (f > 0 && (pk_f[0] == 0 || $signed(x.level) > pk_l[0])) begin
                for (int i = NPK - 1; i > 0; i--) begin
                    pk_f[i] = pk_f[i-1]; pk_l[i] = pk_l[i-1];
                end
                pk_f[0] = f; pk_l[0] = x.level;
            end
        end
        if (x.last) begin
            pitch_q.push_back(pick_pitch());
            clear_peaks();
        end
    endtask

    // driver
    int s_gap = 0;
    always @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            predict_bin(t_bin'({s_axis_tdata[9:0], s_axis_tdata[25:10],
                                s_axis_tdata[41:26], s_axis_tlast}));
            sent++;
        end
        if (!i_rst_n || (s_axis_tvalid && !s_axis_tready)) begin
        end else if (s_gap > 0 || hold || bin_q.size() == 0) begin
            s_axis_tvalid <= 1'b0;
            if (s_gap > 0) s_gap <= s_gap - 1;
        end else begin
            t_bin x;
            x = bin_q.pop_front();
            s_axis_tvalid <= 1'b1;
            s_axis_tdata <= {6'd0, x.phase, x.level, x.bin};
            s_axis_tlast <= x.last;
            s_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
        end
    end

    // monitor
    int m_gap = 0;
    always @(posedge i_clk) begin
        if (m_axis_tvalid && m_axis_tready) begin
            frames++;
            if (pitch_q.size() == 0) report($sformatf("unexpected pitch %h", m_axis_tdata));
            else if (m_axis_tdata != {4'd0, pitch_q[0]} || 1'b0)
                report($sformatf("pitch got %h want %h", m_axis_tdata, pitch_q[0]));
            if (pitch_q.size() != 0) void'(pitch_q.pop_front());
            m_gap = $urandom_range(0, 12);
        end
        if (m_gap > 0) begin
            m_axis_tready <= 1'b0; m_gap = m_gap - 1;
        end else m_axis_tready <= i_rst_n;
    end

    function automatic t_bin rnd_bin(input int b, input bit last);
        t_bin x;
        x.bin = 10'(b);
        x.level = ($urandom_range(0, 1)) ? 16'($urandom_range(0, 65535))
                                         : 16'($urandom_range(0, 8000));
        x.phase = 16'($urandom);
        x.last = last;
        return x;
    endfunction

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] v);
        @(posedge i_clk);
        i_cfg_we <= 1'b1; i_cfg_idx <= idx; i_cfg_wdata <= v;
        case (idx)
            CFG_FREQ_PER_BIN: cf_fpb = v;
            CFG_PHASE_STEP:   cf_step = v[STEP_W-1:0];
            CFG_HOP_RATIO:    cf_hop = v[HOP_W-1:0];
            default:          cf_maxp = v[MAXP_W-1:0];
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic drain();
        while (bin_q.size() != 0 || s_axis_tvalid || pitch_q.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    // a frame of bins spread from a base bin: mostly rising levels so most are pushed as peaks
    task automatic queue_frame(input int nbins);
        int b0, n;
        b0 = $urandom_range(0, 100);
        for (int i = 0; i < nbins; i++) begin
            t_bin x;
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1023) : b0 + i * $urandom_range(1, 5);
            x = rnd_bin(n % 1024, i == nbins - 1);
            if ($urandom_range(0, 2) != 0) x.level = 16'(-3000 + i * 400 + $urandom_range(0, 200));
            bin_q.push_back(x);
        end
    endtask

    initial begin
        for (int i = 0; i < HALF; i++) prev_ph[i] = '0;
        clear_peaks();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // directed: extremes, out-of-range bin, empty frame, harmonic series
        bin_q.push_back('{10'd0, 16'h7FFF, 16'hFFFF, 1'b0});
        bin_q.push_back('{10'd512, 16'h8000, 16'h0000, 1'b0});
        bin_q.push_back('{10'd513, 16'h7FFF, 16'h8000, 1'b0});
        bin_q.push_back('{10'd1023, 16'h0000, 16'h7FFF, 1'b1});
        bin_q.push_back('{10'd1023, 16'h0000, 16'h0000, 1'b1});
        bin_q.push_back('{10'd10, 16'hF000, 16'h0000, 1'b0});
        bin_q.push_back('{10'd20, 16'hF800, 16'h0000, 1'b0});
        bin_q.push_back('{10'd30, 16'hFC00, 16'h0000, 1'b0});
        bin_q.push_back('{10'd50, 16'hFE00, 16'h0000, 1'b1});
        drain();
        hold = 1; queue_frame(6); repeat (30) @(posedge i_clk); hold = 0;
        drain();
        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: begin cfg_write(CFG_FREQ_PER_BIN, 24'd1); cfg_write(CFG_HOP_RATIO, 24'd0); end
                1: begin cfg_write(CFG_FREQ_PER_BIN, 24'hFFFFFF); cfg_write(CFG_MAX_PITCH, 24'hFFFF); end
                2: begin cfg_write(CFG_PHASE_STEP, 24'd0); cfg_write(CFG_HOP_RATIO, 24'd64); end
                3: begin cfg_write(CFG_PHASE_STEP, 24'hFFFF); cfg_write(CFG_MAX_PITCH, 24'd0); end
                4: cfg_write(CFG_FREQ_PER_BIN, 24'd0);
                5: begin cfg_write(CFG_FREQ_PER_BIN, 24'($urandom_range(1, 24'hFFFFFF)));
                       cfg_write(CFG_HOP_RATIO, 24'(1 + $urandom_range(0, 127) % 64)); end
                6: cfg_write(CFG_PHASE_STEP, 24'($urandom_range(0, 65535)));
                default: begin cfg_write(CFG_FREQ_PER_BIN, 24'd11025); cfg_write(CFG_HOP_RATIO, 24'd2);
                       cfg_write(CFG_PHASE_STEP, 24'd32768); cfg_write(CFG_MAX_PITCH, 24'd5000); end
            endcase
            for (int k = 0; k < 230;) begin
                int n;
                n = $urandom_range(1, 14);
                if ($urandom_range(0, 4) == 0)
                    for (int i = 0; i < n; i++)
                        bin_q.push_back(rnd_bin($urandom_range(0, 1023), $urandom_range(0, 9) == 0));
                else queue_frame(n);
                k += n;
            end
            drain();
        end
        $display("covered %0d bins, %0d frames, 8 register settings", sent, frames);
        if (errors == 0)
            $display("phase_vocoder_pitch_comb_unit verification clean");
        else
            $display("phase_vocoder_pitch_comb_unit verification failed");
        $finish;
    end

    initial begin
        #2000000;
        $display("phase_vocoder_pitch_comb_unit verification failed");
        $finish;
    end
endmodule
